[design/qau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types and constants of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

	localparam int DEF_WORD_BITS = 24;
	localparam int DEF_FRAC_BITS = 20;
	localparam int ROW_BITS      = 2;
	localparam int NUM_SLOTS     = 9;

	// Request codes
	typedef enum logic [2:0] {
		OP_MUL   = 3'd0,
		OP_ROT   = 3'd1,
		OP_MAT   = 3'd2,
		OP_DOT   = 3'd3,
		OP_SCALE = 3'd4,
		OP_ADD   = 3'd5,
		OP_CONJ  = 3'd6
	} qau_op_t;

	// Code with no operation behind it: the request is dropped
	localparam logic [2:0] REQ_UNKNOWN = 3'd7;

	// Stage control travelling with the data
	typedef struct packed {
		logic    valid;
		qau_op_t op;
	} qau_ctrl_t;

endpackage

[design/qau_rndsat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_rndsat
// Round an exact fixed-point sum to nearest (ties up) and saturate to a word.
// ----------------------------------------------------------------------------
module qau_rndsat #(
	parameter int WORD_BITS = 24,
	parameter int FRAC_BITS = 20,
	parameter int SUM_BITS  = 53
) (
	input  logic signed [SUM_BITS-1:0]  sum,
	output logic signed [WORD_BITS-1:0] word,
	output logic                        sat
);
	localparam int RW = SUM_BITS - FRAC_BITS;
	localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(1) << (FRAC_BITS - 1);
	localparam logic signed [RW-1:0] MAXV =
		{{(RW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
	localparam logic signed [RW-1:0] MINV = ~MAXV;

	logic signed [SUM_BITS-1:0] biased;
	logic signed [RW-1:0]       rnd;

	assign biased = sum + HALF;
	assign rnd    = biased[SUM_BITS-1:FRAC_BITS];

	// Clamp to the word range
	always_comb begin
		sat  = 1'b0;
		word = rnd[WORD_BITS-1:0];
		if (rnd > MAXV) begin
			sat  = 1'b1;
			word = MAXV[WORD_BITS-1:0];
		end else if (rnd < MINV) begin
			sat  = 1'b1;
			word = MINV[WORD_BITS-1:0];
		end
	end

endmodule

[design/qau_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_front
// First pass: sixteen operand products, per-slot sums, round and saturate.
// ----------------------------------------------------------------------------
module qau_front import qau_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qau_ctrl_t                   in_ctrl,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] p_in [4],
	input  logic signed [WORD_BITS-1:0] q_in [4],
	input  logic signed [WORD_BITS-1:0] s_in,
	output qau_ctrl_t                   out_ctrl,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] p_out [4],
	output logic signed [WORD_BITS-1:0] words [NUM_SLOTS],
	output logic [2:0]                  row_ovf
);
	localparam int W  = WORD_BITS;
	localparam int OW = W + 1;
	localparam int PW = 2 * OW;
	localparam int SW = PW + 3;
	// 1.0 at the scale of a full product (2 * FRAC_BITS fraction bits)
	localparam logic signed [SW-1:0] ONE = SW'(1) << (2 * FRAC_BITS);

	qau_ctrl_t ctrl_s1, ctrl_s2, ctrl_s3;
	logic en1, en2, en3;

	logic signed [OW-1:0] a_op [4];
	logic signed [OW-1:0] b_op [4];
	logic signed [PW-1:0] prod_s1 [4][4];
	logic signed [W-1:0]  p_s1 [4];
	logic signed [W-1:0]  q_s1 [4];

	logic signed [SW-1:0] e [4][4];
	logic signed [SW-1:0] sum_c [NUM_SLOTS];
	logic signed [SW-1:0] sum_s2 [NUM_SLOTS];
	logic signed [W-1:0]  p_s2 [4];

	logic signed [W-1:0]  rnd_w [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] rnd_o;
	logic signed [W-1:0]  words_s3 [NUM_SLOTS];
	logic [2:0]           ovf_s3;
	logic signed [W-1:0]  p_s3 [4];

	// Stall chain: a stage moves when it is empty or its successor moves
	assign en3      = !ctrl_s3.valid || out_ready;
	assign en2      = !ctrl_s2.valid || en3;
	assign en1      = !ctrl_s1.valid || en2;
	assign in_ready = en1;

	// Operand selection
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a_op[i] = {p_in[i][W-1], p_in[i]};
			b_op[i] = {q_in[i][W-1], q_in[i]};
		end
		case (in_ctrl.op)
			OP_ROT: begin
				// v * conj(p), v = (0, q vector)
				a_op[0] = '0;
				b_op[0] = {p_in[0][W-1], p_in[0]};
				for (int i = 1; i < 4; i++) begin
					a_op[i] = {q_in[i][W-1], q_in[i]};
					b_op[i] = -{p_in[i][W-1], p_in[i]};
				end
			end
			OP_MAT: begin
				for (int i = 0; i < 4; i++)
					b_op[i] = {p_in[i][W-1], p_in[i]};
			end
			OP_SCALE: begin
				for (int i = 0; i < 4; i++)
					b_op[i] = {s_in[W-1], s_in};
			end
			default: ;
		endcase
	end

	// Stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1.valid <= 1'b0;
			ctrl_s1.op    <= OP_MUL;
		end else if (en1) begin
			ctrl_s1 <= in_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 4; i++) begin
				p_s1[i] <= p_in[i];
				q_s1[i] <= q_in[i];
				for (int j = 0; j < 4; j++)
					prod_s1[i][j] <= a_op[i] * b_op[j];
			end
		end
	end

	// Stage 2: exact sums per result slot
	always_comb begin
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				e[i][j] = SW'(prod_s1[i][j]);
	end

	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++)
			sum_c[k] = '0;
		case (ctrl_s1.op)
			OP_MUL, OP_ROT: begin
				sum_c[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
				sum_c[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
				sum_c[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
				sum_c[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
			end
			OP_MAT: begin
				// w=0 x=1 y=2 z=3; every product sum is doubled by a left shift
				sum_c[0] = ONE - ((e[2][2] + e[3][3]) <<< 1);
				sum_c[1] = (e[1][2] + e[0][3]) <<< 1;
				sum_c[2] = (e[1][3] - e[0][2]) <<< 1;
				sum_c[3] = (e[1][2] - e[0][3]) <<< 1;
				sum_c[4] = ONE - ((e[3][3] + e[1][1]) <<< 1);
				sum_c[5] = (e[2][3] + e[0][1]) <<< 1;
				sum_c[6] = (e[1][3] + e[0][2]) <<< 1;
				sum_c[7] = (e[2][3] - e[0][1]) <<< 1;
				sum_c[8] = ONE - ((e[1][1] + e[2][2]) <<< 1);
			end
			OP_DOT: begin
				sum_c[0] = e[0][0] + e[1][1] + e[2][2] + e[3][3];
			end
			OP_SCALE: begin
				for (int i = 0; i < 4; i++)
					sum_c[i] = e[i][i];
			end
			OP_ADD: begin
				for (int i = 0; i < 4; i++)
					sum_c[i] = (SW'(p_s1[i]) + SW'(q_s1[i])) <<< FRAC_BITS;
			end
			OP_CONJ: begin
				sum_c[0] = SW'(p_s1[0]) <<< FRAC_BITS;
				for (int i = 1; i < 4; i++)
					sum_c[i] = (-SW'(p_s1[i])) <<< FRAC_BITS;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2.valid <= 1'b0;
			ctrl_s2.op    <= OP_MUL;
		end else if (en2) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2   <= p_s1;
			sum_s2 <= sum_c;
		end
	end

	// Stage 3: round and saturate every slot
	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_rnd
		qau_rndsat #(
			.WORD_BITS (W),
			.FRAC_BITS (FRAC_BITS),
			.SUM_BITS  (SW)
		) u_rnd (
			.sum  (sum_s2[k]),
			.word (rnd_w[k]),
			.sat  (rnd_o[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3.valid <= 1'b0;
			ctrl_s3.op    <= OP_MUL;
		end else if (en3) begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			p_s3     <= p_s2;
			words_s3 <= rnd_w;
			if (ctrl_s2.op == OP_MAT) begin
				ovf_s3 <= {|rnd_o[8:6], |rnd_o[5:3], |rnd_o[2:0]};
			end else begin
				ovf_s3 <= {2'b00, |rnd_o[3:0]};
			end
		end
	end

	assign out_ctrl = ctrl_s3;
	assign p_out    = p_s3;
	assign words    = words_s3;
	assign row_ovf  = ovf_s3;

endmodule

[design/qau_rot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_rot
// Second pass: p * t for vector rotation; other requests ride through.
// ----------------------------------------------------------------------------
module qau_rot import qau_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qau_ctrl_t                   in_ctrl,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] p_in [4],
	input  logic signed [WORD_BITS-1:0] words_in [NUM_SLOTS],
	input  logic [2:0]                  ovf_in,
	output qau_ctrl_t                   out_ctrl,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] words [NUM_SLOTS],
	output logic [2:0]                  row_ovf
);
	localparam int W  = WORD_BITS;
	localparam int OW = W + 1;
	localparam int PW = 2 * OW;
	localparam int SW = PW + 3;

	qau_ctrl_t ctrl_s4, ctrl_s5, ctrl_s6;
	logic en4, en5, en6;

	logic signed [PW-1:0] prod_s4 [4][4];
	logic signed [W-1:0]  words_s4 [NUM_SLOTS];
	logic [2:0]           ovf_s4;

	logic signed [SW-1:0] e [4][4];
	logic signed [SW-1:0] sum_s5 [4];
	logic signed [W-1:0]  words_s5 [NUM_SLOTS];
	logic [2:0]           ovf_s5;

	logic signed [W-1:0]  rnd_w [4];
	logic [3:0]           rnd_o;
	logic signed [W-1:0]  words_c [NUM_SLOTS];
	logic [2:0]           ovf_c;
	logic signed [W-1:0]  words_s6 [NUM_SLOTS];
	logic [2:0]           ovf_s6;

	assign en6      = !ctrl_s6.valid || out_ready;
	assign en5      = !ctrl_s5.valid || en6;
	assign en4      = !ctrl_s4.valid || en5;
	assign in_ready = en4;

	// Stage 4: products of p and the rounded t
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s4.valid <= 1'b0;
			ctrl_s4.op    <= OP_MUL;
		end else if (en4) begin
			ctrl_s4 <= in_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			words_s4 <= words_in;
			ovf_s4   <= ovf_in;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					prod_s4[i][j] <= OW'(p_in[i]) * OW'(words_in[j]);
		end
	end

	// Stage 5: Hamilton product sums
	always_comb begin
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				e[i][j] = SW'(prod_s4[i][j]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s5.valid <= 1'b0;
			ctrl_s5.op    <= OP_MUL;
		end else if (en5) begin
			ctrl_s5 <= ctrl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			words_s5  <= words_s4;
			ovf_s5    <= ovf_s4;
			sum_s5[0] <= e[0][0] - e[1][1] - e[2][2] - e[3][3];
			sum_s5[1] <= e[0][1] + e[1][0] + e[2][3] - e[3][2];
			sum_s5[2] <= e[0][2] - e[1][3] + e[2][0] + e[3][1];
			sum_s5[3] <= e[0][3] + e[1][2] - e[2][1] + e[3][0];
		end
	end

	// Stage 6: round; scalar part is computed for the flag and then dropped
	for (genvar k = 0; k < 4; k++) begin : g_rnd
		qau_rndsat #(
			.WORD_BITS (W),
			.FRAC_BITS (FRAC_BITS),
			.SUM_BITS  (SW)
		) u_rnd (
			.sum  (sum_s5[k]),
			.word (rnd_w[k]),
			.sat  (rnd_o[k])
		);
	end

	// Rotation takes the vector part of p * t; other requests pass unchanged
	always_comb begin
		words_c = words_s5;
		ovf_c   = ovf_s5;
		if (ctrl_s5.op == OP_ROT) begin
			words_c[0] = '0;
			words_c[1] = rnd_w[1];
			words_c[2] = rnd_w[2];
			words_c[3] = rnd_w[3];
			ovf_c[0]   = ovf_s5[0] | (|rnd_o);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s6.valid <= 1'b0;
			ctrl_s6.op    <= OP_MUL;
		end else if (en6) begin
			ctrl_s6 <= ctrl_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			words_s6 <= words_c;
			ovf_s6   <= ovf_c;
		end
	end

	assign out_ctrl = ctrl_s6;
	assign words    = words_s6;
	assign row_ovf  = ovf_s6;

endmodule

[design/qau_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_out
// Result sequencer: one beat per request, three row beats for a matrix.
// ----------------------------------------------------------------------------
module qau_out import qau_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qau_ctrl_t                   in_ctrl,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] words [NUM_SLOTS],
	input  logic [2:0]                  row_ovf,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic signed [WORD_BITS-1:0] r_a,
	output logic signed [WORD_BITS-1:0] r_x,
	output logic signed [WORD_BITS-1:0] r_y,
	output logic signed [WORD_BITS-1:0] r_z,
	output logic [ROW_BITS-1:0]         row_index,
	output logic                        overflow,
	output logic                        last
);
	localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(2);

	logic [ROW_BITS-1:0] row_q;
	logic                is_mat;

	assign is_mat    = (in_ctrl.op == OP_MAT);
	assign res_valid = in_ctrl.valid;
	assign in_ready  = res_ready && last;

	// Field selection for the current beat
	always_comb begin
		r_a       = words[0];
		r_x       = words[1];
		r_y       = words[2];
		r_z       = words[3];
		row_index = '0;
		overflow  = row_ovf[0];
		last      = 1'b1;
		if (is_mat) begin
			r_a       = '0;
			row_index = row_q;
			last      = (row_q == ROW_LAST);
			case (row_q)
				2'd0: begin
					r_x      = words[0];
					r_y      = words[1];
					r_z      = words[2];
					overflow = row_ovf[0];
				end
				2'd1: begin
					r_x      = words[3];
					r_y      = words[4];
					r_z      = words[5];
					overflow = row_ovf[1];
				end
				default: begin
					r_x      = words[6];
					r_y      = words[7];
					r_z      = words[8];
					overflow = row_ovf[2];
				end
			endcase
		end
	end

	// Row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (res_valid && res_ready) begin
			if (last) begin
				row_q <= '0;
			end else begin
				row_q <= row_q + ROW_BITS'(1);
			end
		end
	end

endmodule

[design/quaternion_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core
// Pipelined fixed-point quaternion ALU with rounding and saturation.
// ----------------------------------------------------------------------------
// A new request is taken every clock cycle unless the pipeline stalls; its
// first result is presented once it has passed all six register stages.
// Product, rotate, dot, scale, add and conjugate give one result each. A
// matrix request gives three row results and holds the final stage until its
// last row is taken, so the request rate is set by the output sequencer in
// matrix mode and by the single multiplier pass per stage otherwise. Rotation
// uses two multiplier passes (v*conj(p) then p*t), six register stages in all.
// Request code 7 is taken and dropped.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_core import qau_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [2:0]                  req_type,
	input  logic signed [WORD_BITS-1:0] p_a,
	input  logic signed [WORD_BITS-1:0] p_x,
	input  logic signed [WORD_BITS-1:0] p_y,
	input  logic signed [WORD_BITS-1:0] p_z,
	input  logic signed [WORD_BITS-1:0] q_a,
	input  logic signed [WORD_BITS-1:0] q_x,
	input  logic signed [WORD_BITS-1:0] q_y,
	input  logic signed [WORD_BITS-1:0] q_z,
	input  logic signed [WORD_BITS-1:0] scale,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic signed [WORD_BITS-1:0] r_a,
	output logic signed [WORD_BITS-1:0] r_x,
	output logic signed [WORD_BITS-1:0] r_y,
	output logic signed [WORD_BITS-1:0] r_z,
	output logic [ROW_BITS-1:0]         row_index,
	output logic                        overflow,
	output logic                        last
);
	qau_ctrl_t req_ctrl, f_ctrl, r_ctrl;
	logic f_ready, r_ready;

	logic signed [WORD_BITS-1:0] p_vec [4];
	logic signed [WORD_BITS-1:0] q_vec [4];
	logic signed [WORD_BITS-1:0] f_p [4];
	logic signed [WORD_BITS-1:0] f_words [NUM_SLOTS];
	logic [2:0]                  f_ovf;
	logic signed [WORD_BITS-1:0] r_words [NUM_SLOTS];
	logic [2:0]                  r_ovf;

	// Unknown request codes are accepted but never enter the pipeline
	assign req_ctrl.valid = req_valid && (req_type != REQ_UNKNOWN);
	assign req_ctrl.op    = qau_op_t'(req_type);

	assign p_vec = '{p_a, p_x, p_y, p_z};
	assign q_vec = '{q_a, q_x, q_y, q_z};

	qau_front #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctrl   (req_ctrl),
		.in_ready  (req_ready),
		.p_in      (p_vec),
		.q_in      (q_vec),
		.s_in      (scale),
		.out_ctrl  (f_ctrl),
		.out_ready (f_ready),
		.p_out     (f_p),
		.words     (f_words),
		.row_ovf   (f_ovf)
	);

	qau_rot #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctrl   (f_ctrl),
		.in_ready  (f_ready),
		.p_in      (f_p),
		.words_in  (f_words),
		.ovf_in    (f_ovf),
		.out_ctrl  (r_ctrl),
		.out_ready (r_ready),
		.words     (r_words),
		.row_ovf   (r_ovf)
	);

	qau_out #(
		.WORD_BITS (WORD_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctrl   (r_ctrl),
		.in_ready  (r_ready),
		.words     (r_words),
		.row_ovf   (r_ovf),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.r_a       (r_a),
		.r_x       (r_x),
		.r_y       (r_y),
		.r_z       (r_z),
		.row_index (row_index),
		.overflow  (overflow),
		.last      (last)
	);

endmodule
